### design/jwmf_pkg.sv
// Shared constants, FSM state type and controller/datapath interface structs.
`default_nettype none

package jwmf_pkg;

    // Default sizes
    localparam int JOINTS_DEF     = 8;
    localparam int WINDOW_DEF     = 8;
    localparam int COORD_BITS_DEF = 16;

    // Fixed port field widths
    localparam int JOINT_BITS = 3;
    localparam int IN_BITS    = 16;
    localparam int OUT_BITS   = 16;

    // Controller states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_WRITE,
        S_READ,
        S_DRAIN,
        S_DONE
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic clr;    // zero one history entry, advance clear address
        logic load;   // capture request fields, empty the sorters
        logic write;  // store sample at joint's head if it is present
        logic rd;     // read one ring entry, advance read index
        logic fin;    // load the result registers
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic clr_last;  // clear address at last entry
        logic rd_last;   // read index at last ring slot
        logic in_range;  // captured joint number is below JOINTS
    } t_stat;

endpackage

`default_nettype wire

### design/joint_window_median_filter.sv
// Top level of the per-joint sliding-window median filter.
//
//  channel  direction  handshake           payload
//  request  in         i_valid / o_ready   i_joint, i_sample_x, i_sample_y, i_sample_z
//  result   out        o_valid / i_ready   o_median_x, o_median_y, o_median_z
//
// A request goes from accept through a write state, a read of each ring
// slot from the single-port history memory, a drain state for the
// registered read and a result state to the next accept. A joint number
// not below JOINTS skips the read and drain states. After reset a clearing
// pass zeroes the history memory; o_ready stays low.
// A new request is taken while a result waits; a full result stage holds
// the next result in its last cycle.
`default_nettype none

module joint_window_median_filter #(
    parameter int JOINTS     = jwmf_pkg::JOINTS_DEF,
    parameter int WINDOW     = jwmf_pkg::WINDOW_DEF,
    parameter int COORD_BITS = jwmf_pkg::COORD_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic [jwmf_pkg::JOINT_BITS-1:0] i_joint,
    input  wire logic [jwmf_pkg::IN_BITS-1:0]    i_sample_x,
    input  wire logic [jwmf_pkg::IN_BITS-1:0]    i_sample_y,
    input  wire logic [jwmf_pkg::IN_BITS-1:0]    i_sample_z,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic      [jwmf_pkg::OUT_BITS-1:0]   o_median_x,
    output logic      [jwmf_pkg::OUT_BITS-1:0]   o_median_y,
    output logic      [jwmf_pkg::OUT_BITS-1:0]   o_median_z
);
    import jwmf_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    jwmf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (cmd),
        .i_stat  (stat)
    );

    jwmf_dp #(
        .JOINTS     (JOINTS),
        .WINDOW     (WINDOW),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_joint    (i_joint),
        .i_sample_x (i_sample_x),
        .i_sample_y (i_sample_y),
        .i_sample_z (i_sample_z),
        .o_median_x (o_median_x),
        .o_median_y (o_median_y),
        .o_median_z (o_median_z)
    );

endmodule

`default_nettype wire

### design/jwmf_sorter.sv
// Insertion sorter for one coordinate: keeps nonzero values in ascending order.
`default_nettype none

module jwmf_sorter #(
    parameter int WINDOW     = jwmf_pkg::WINDOW_DEF,
    parameter int COORD_BITS = jwmf_pkg::COORD_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_clr,
    input  wire logic                  i_ins,
    input  wire logic [COORD_BITS-1:0] i_din,
    output logic      [COORD_BITS-1:0] o_median
);
    import jwmf_pkg::*;

    localparam int WW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CW = $clog2(WINDOW + 1);

    logic [WINDOW-1:0][COORD_BITS-1:0] r_slot;
    logic [WINDOW-1:0][COORD_BITS-1:0] n_slot;
    logic [CW-1:0]                     r_cnt;
    logic [CW-1:0]                     n_cnt;
    logic [WINDOW-1:0]                 gt;
    logic                              do_ins;
    logic [CW-1:0]                     half;

    // Zero entries are never counted
    assign do_ins = i_ins && (i_din != '0);

    // Each slot either keeps, takes the new value, or shifts up from below
    for (genvar j = 0; j < WINDOW; j++) begin : g_slot
        logic [COORD_BITS-1:0] prev;
        logic                  first;
        if (j == 0) begin : g_lo
            assign prev  = i_din;
            assign first = 1'b1;
        end else begin : g_hi
            assign prev  = r_slot[j-1];
            assign first = !gt[j-1];
        end
        assign gt[j]     = (CW'(j) < r_cnt) && (i_din < r_slot[j]);
        assign n_slot[j] = !do_ins          ? r_slot[j] :
                           gt[j]            ? (first ? i_din : prev) :
                           (CW'(j) == r_cnt) ? (first ? i_din : prev) : r_slot[j];
    end

    // Fill count
    always_comb begin
        n_cnt = r_cnt;
        if (i_clr) begin
            n_cnt = '0;
        end else if (do_ins) begin
            n_cnt = r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

    // Upper median: rank count/2 from the bottom
    assign half     = r_cnt >> 1;
    assign o_median = (r_cnt == '0) ? '0 : r_slot[half[WW-1:0]];

    // Count never exceeds the window
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cnt) <= WINDOW)
        else $error("sorter count beyond window");

    // Each nonzero insert grows the count by one
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_ins && !i_clr) |=> (r_cnt == CW'($past(r_cnt) + 1'b1)))
        else $error("sorter count did not advance on insert");

endmodule

`default_nettype wire

### design/jwmf_dp.sv
// Datapath: history memory, write heads, ring readout and three sorters.
`default_nettype none

module jwmf_dp #(
    parameter int JOINTS     = jwmf_pkg::JOINTS_DEF,
    parameter int WINDOW     = jwmf_pkg::WINDOW_DEF,
    parameter int COORD_BITS = jwmf_pkg::COORD_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire jwmf_pkg::t_cmd                    i_cmd,
    output jwmf_pkg::t_stat                        o_stat,
    input  wire logic [jwmf_pkg::JOINT_BITS-1:0]   i_joint,
    input  wire logic [jwmf_pkg::IN_BITS-1:0]      i_sample_x,
    input  wire logic [jwmf_pkg::IN_BITS-1:0]      i_sample_y,
    input  wire logic [jwmf_pkg::IN_BITS-1:0]      i_sample_z,
    output logic      [jwmf_pkg::OUT_BITS-1:0]     o_median_x,
    output logic      [jwmf_pkg::OUT_BITS-1:0]     o_median_y,
    output logic      [jwmf_pkg::OUT_BITS-1:0]     o_median_z
);
    import jwmf_pkg::*;

    localparam int CB    = COORD_BITS;
    localparam int DEPTH = JOINTS * WINDOW;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int JW    = (JOINTS > 1) ? $clog2(JOINTS) : 1;
    localparam int WW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int JXW   = (JW > JOINT_BITS) ? JW : JOINT_BITS;

    logic [JOINT_BITS-1:0] r_joint;
    logic [CB-1:0]         r_x, r_y, r_z;
    logic [WW-1:0]         r_head [JOINTS];
    logic [AW-1:0]         r_clr_addr;
    logic [WW-1:0]         r_rd_idx;
    logic                  r_rd_vld;
    logic [3*CB-1:0]       r_rdata;
    logic [3*CB-1:0]       r_mem [DEPTH];
    logic [OUT_BITS-1:0]   r_med_x, r_med_y, r_med_z;

    logic [JXW-1:0]  joint_ext;
    logic [JW-1:0]   jidx;
    logic            in_range;
    logic            hit;
    logic [WW-1:0]   head_cur;
    logic [WW-1:0]   n_head;
    logic [AW-1:0]   base;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [3*CB-1:0] mem_wdata;
    logic [AW-1:0]   rd_addr;
    logic [CB-1:0]   med_x, med_y, med_z;

    // Joint decode
    assign joint_ext = JXW'(r_joint);
    assign jidx      = joint_ext[JW-1:0];
    assign in_range  = (32'(r_joint) < 32'(JOINTS));
    assign hit       = in_range && (r_x != '0);
    assign head_cur  = r_head[jidx];
    assign n_head    = (32'(head_cur) == WINDOW - 1) ? '0 : head_cur + 1'b1;
    assign base      = AW'(jidx) * AW'(WINDOW);

    // Memory write port: clearing pass or sample store
    assign mem_we    = i_cmd.clr || (i_cmd.write && hit);
    assign mem_waddr = i_cmd.clr ? r_clr_addr : base + AW'(head_cur);
    assign mem_wdata = i_cmd.clr ? '0 : {r_z, r_y, r_x};
    assign rd_addr   = base + AW'(r_rd_idx);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.rd) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // Request capture, masked to coordinate width
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_joint <= i_joint;
            r_x     <= CB'(i_sample_x);
            r_y     <= CB'(i_sample_y);
            r_z     <= CB'(i_sample_z);
        end
    end

    // Write heads, clear address, read index, read-data valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < JOINTS; i++) begin
                r_head[i] <= '0;
            end
            r_clr_addr <= '0;
            r_rd_idx   <= '0;
            r_rd_vld   <= 1'b0;
        end else begin
            if (i_cmd.write && hit) begin
                r_head[jidx] <= n_head;
            end
            if (i_cmd.clr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.load) begin
                r_rd_idx <= '0;
            end else if (i_cmd.rd) begin
                r_rd_idx <= r_rd_idx + 1'b1;
            end
            r_rd_vld <= i_cmd.rd;
        end
    end

    // One sorter per coordinate
    jwmf_sorter #(.WINDOW(WINDOW), .COORD_BITS(CB)) u_sort_x (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clr    (i_cmd.load),
        .i_ins    (r_rd_vld),
        .i_din    (r_rdata[CB-1:0]),
        .o_median (med_x)
    );

    jwmf_sorter #(.WINDOW(WINDOW), .COORD_BITS(CB)) u_sort_y (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clr    (i_cmd.load),
        .i_ins    (r_rd_vld),
        .i_din    (r_rdata[2*CB-1:CB]),
        .o_median (med_y)
    );

    jwmf_sorter #(.WINDOW(WINDOW), .COORD_BITS(CB)) u_sort_z (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clr    (i_cmd.load),
        .i_ins    (r_rd_vld),
        .i_din    (r_rdata[3*CB-1:2*CB]),
        .o_median (med_z)
    );

    // Result registers; unknown joint gives zeros
    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_med_x <= in_range ? OUT_BITS'(med_x) : '0;
            r_med_y <= in_range ? OUT_BITS'(med_y) : '0;
            r_med_z <= in_range ? OUT_BITS'(med_z) : '0;
        end
    end

    assign o_median_x = r_med_x;
    assign o_median_y = r_med_y;
    assign o_median_z = r_med_z;

    // Status
    assign o_stat.clr_last = (r_clr_addr == AW'(DEPTH - 1));
    assign o_stat.rd_last  = (32'(r_rd_idx) == WINDOW - 1);
    assign o_stat.in_range = in_range;

endmodule

`default_nettype wire

### design/jwmf_ctrl.sv
// Controller FSM: clearing pass, request sequencing and result handoff.
`default_nettype none

module jwmf_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output jwmf_pkg::t_cmd       o_cmd,
    input  wire jwmf_pkg::t_stat i_stat
);
    import jwmf_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_o_valid;
    logic   out_free;

    // Result register can take a new value
    assign out_free = !r_o_valid || i_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (i_stat.clr_last) n_state = S_IDLE;
            S_IDLE:  if (i_valid)         n_state = S_WRITE;
            S_WRITE: n_state = i_stat.in_range ? S_READ : S_DONE;
            S_READ:  if (i_stat.rd_last)  n_state = S_DRAIN;
            S_DRAIN: n_state = S_DONE;
            S_DONE:  if (out_free)        n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_CLEAR: o_cmd.clr = 1'b1;
            S_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_valid;
            end
            S_WRITE: o_cmd.write = 1'b1;
            S_READ:  o_cmd.rd    = 1'b1;
            S_DRAIN: o_cmd       = '0;
            S_DONE:  o_cmd.fin   = out_free;
            default: o_cmd       = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.fin) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_o_valid;

    // A pending result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.fin |-> (!r_o_valid || i_ready))
        else $error("result overwritten while still pending");

    // A blocked result stays in DONE
    a_done_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_o_valid && !i_ready) |=> (r_state == S_DONE))
        else $error("left DONE while output blocked");

endmodule

`default_nettype wire
